// ----- rtl/cls_pkg.sv -----
// shared types and constants of the character lcd shadow differ
package cls_pkg;

  // default display geometry
  localparam int unsigned ROWS_DEF = 4;
  localparam int unsigned COLS_DEF = 20;

  // special characters
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // item commands
  typedef enum logic [2:0] {
    MODE_WR_IMG = 3'd0,
    MODE_WR_TAG = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_SCAN   = 3'd3,
    MODE_CMP    = 3'd4,
    MODE_TAGS   = 3'd5
  } mode_e;

  // refresh kinds
  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_CHAR = 2'd2
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LINES,
    ST_TAGS,
    ST_WALK,
    ST_FINISH
  } ctrl_state_e;

  // input item payload
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] row;
    logic [4:0] col_first;
    logic [4:0] col_last;
    logic [7:0] char_value;
    logic       with_tags;
  } item_t;

  // result payload
  typedef struct packed {
    kind_e      kind;
    logic [1:0] out_row;
    logic [4:0] out_col;
    logic [7:0] out_char;
    logic       last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic fill_space;
    logic line_step;
    logic tag_step;
    logic walk_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  sweep_last;
    logic  tr_last;
    logic  can_push;
    logic  tag_adv;
    logic  walk_done;
    logic  fin_ok;
  } sts_t;

endpackage

// ----- rtl/cls_item_if.sv -----
// input item channel
interface cls_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] row;
  logic [4:0] col_first;
  logic [4:0] col_last;
  logic [7:0] char_value;
  logic       with_tags;

  modport source (
    output valid, mode, row, col_first, col_last, char_value, with_tags,
    input  ready
  );
  modport sink (
    input  valid, mode, row, col_first, col_last, char_value, with_tags,
    output ready
  );
endinterface

// ----- rtl/cls_res_if.sv -----
// result channel
interface cls_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] out_row;
  logic [4:0] out_col;
  logic [7:0] out_char;
  logic       last;

  modport source (
    output valid, kind, out_row, out_col, out_char, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_row, out_col, out_char, last,
    output ready
  );
endinterface

// ----- rtl/cls_dp.sv -----
// datapath: image and shadow memories, tags, walker and output stage
module cls_dp #(
  parameter int unsigned ROWS = cls_pkg::ROWS_DEF,
  parameter int unsigned COLS = cls_pkg::COLS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cls_pkg::item_t item_i,
  input  cls_pkg::cmd_t  cmd_i,
  output cls_pkg::sts_t  sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output cls_pkg::res_t  out_o
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CIW   = $clog2(COLS);

  localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0]  COLS_A    = AW'(COLS);
  localparam logic [RIW-1:0] ROW_LAST  = RIW'(ROWS - 1);
  localparam logic [CIW-1:0] COL_LAST  = CIW'(COLS - 1);

  logic [7:0] img_mem [DEPTH];
  logic [7:0] shd_mem [DEPTH];
  logic [7:0] tag_img_q [ROWS];
  logic [7:0] tag_shd_q [ROWS];

  cls_pkg::mode_e in_mode, mode_q;
  logic           row_ok, col_ok, scan_en;
  logic [RIW-1:0] in_row;
  logic [CIW-1:0] in_cf, in_cend;
  logic [AW-1:0]  wr_addr, rd_addr;

  logic [AW-1:0]  sw_q;
  logic [RIW-1:0] tr_q, rw_q, rd_row_q;
  logic [CIW-1:0] cw_q, cend_q, rd_col_q;
  logic           more_q, rd_v_q, diff_q;
  logic [AW-1:0]  rd_addr_q;
  logic [7:0]     img_rd_q, shd_rd_q;

  logic           sweep_last, tr_last, tag_need, tag_adv;
  logic           is_scan, differ, row_end, dsum, emit_need, walk_adv, issue, walk_wr;
  logic [7:0]     fill;

  logic           out_v_q, hold_v_q, out_free, can_push, push_v, fin_move;
  cls_pkg::res_t  out_q, hold_q, push_res, fin_res;

  // decode of an incoming item
  always_comb begin
    in_mode = cls_pkg::mode_e'(item_i.mode);
    row_ok  = int'(item_i.row) < ROWS;
    col_ok  = int'(item_i.col_first) < COLS;
    in_row  = RIW'(item_i.row);
    in_cf   = CIW'(item_i.col_first);
    in_cend = (int'(item_i.col_last) >= COLS) ? COL_LAST : CIW'(item_i.col_last);
    scan_en = row_ok && col_ok && (in_cf <= in_cend);
  end

  assign wr_addr = AW'(in_row) * COLS_A + AW'(in_cf);
  assign rd_addr = AW'(rw_q) * COLS_A + AW'(cw_q);

  // sweep and tag counters
  assign sweep_last = (sw_q == ADDR_LAST);
  assign tr_last    = (tr_q == ROW_LAST);
  assign tag_need   = (tag_img_q[tr_q] != tag_shd_q[tr_q]);
  assign tag_adv    = !tag_need || can_push;
  assign fill       = cmd_i.fill_space ? cls_pkg::CHAR_SPACE : cls_pkg::CHAR_NUL;

  // compare of the cell held in the read registers
  always_comb begin
    is_scan   = (mode_q == cls_pkg::MODE_SCAN);
    differ    = (img_rd_q != shd_rd_q);
    row_end   = (rd_col_q == COL_LAST);
    dsum      = diff_q | differ;
    if (is_scan) begin
      emit_need = rd_v_q && (img_rd_q != cls_pkg::CHAR_NUL) && differ;
    end else begin
      emit_need = rd_v_q && row_end && dsum;
    end
    walk_adv  = !emit_need || can_push;
    issue     = cmd_i.walk_step && walk_adv && more_q;
    walk_wr   = cmd_i.walk_step && rd_v_q && walk_adv && (!is_scan || emit_need);
  end

  // output stage: a hold slot ahead of the output register marks the final result
  assign out_free = !out_v_q || out_ready_i;
  assign can_push = !hold_v_q || out_free;
  assign fin_move = cmd_i.finish && hold_v_q && out_free;

  always_comb begin
    push_v            = 1'b0;
    push_res.kind     = cls_pkg::KIND_LINE;
    push_res.out_row  = 2'(tr_q);
    push_res.out_col  = '0;
    push_res.out_char = '0;
    push_res.last     = 1'b0;
    if (cmd_i.line_step) begin
      push_v = can_push;
    end else if (cmd_i.tag_step) begin
      push_v            = tag_need && can_push;
      push_res.kind     = cls_pkg::KIND_TAG;
      push_res.out_char = tag_img_q[tr_q];
    end else if (cmd_i.walk_step) begin
      push_v           = emit_need && can_push;
      push_res.out_row = 2'(rd_row_q);
      if (is_scan) begin
        push_res.kind     = cls_pkg::KIND_CHAR;
        push_res.out_col  = 5'(rd_col_q);
        push_res.out_char = img_rd_q;
      end
    end
    fin_res      = hold_q;
    fin_res.last = 1'b1;
  end

  // output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else if (push_v) begin
      hold_v_q <= 1'b1;
      if (hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end else if (fin_move) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (push_v) begin
      hold_q <= push_res;
      if (hold_v_q) begin
        out_q <= hold_q;
      end
    end else if (fin_move) begin
      out_q <= fin_res;
    end
  end

  // tag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        tag_img_q[i] <= '0;
        tag_shd_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accept && in_mode == cls_pkg::MODE_WR_TAG && row_ok) begin
        tag_img_q[in_row] <= item_i.char_value;
      end
      if (cmd_i.tag_step && tag_need && can_push) begin
        tag_shd_q[tr_q] <= tag_img_q[tr_q];
      end
    end
  end

  // counters and walker control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cls_pkg::MODE_WR_IMG;
      sw_q   <= '0;
      tr_q   <= '0;
      rw_q   <= '0;
      cw_q   <= '0;
      cend_q <= '0;
      more_q <= 1'b0;
      rd_v_q <= 1'b0;
      diff_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q <= in_mode;
        tr_q   <= '0;
        diff_q <= 1'b0;
        rd_v_q <= 1'b0;
        cend_q <= in_cend;
        if (in_mode == cls_pkg::MODE_CMP) begin
          rw_q   <= '0;
          cw_q   <= '0;
          more_q <= 1'b1;
        end else begin
          rw_q   <= in_row;
          cw_q   <= in_cf;
          more_q <= (in_mode == cls_pkg::MODE_SCAN) && scan_en;
        end
      end
      if (cmd_i.sweep) begin
        sw_q <= sweep_last ? '0 : sw_q + 1'b1;
      end
      if ((cmd_i.tag_step && tag_adv) || (cmd_i.line_step && can_push)) begin
        tr_q <= tr_last ? '0 : tr_q + 1'b1;
      end
      if (cmd_i.walk_step && walk_adv) begin
        rd_v_q <= issue;
        if (rd_v_q && !is_scan) begin
          diff_q <= row_end ? 1'b0 : dsum;
        end
        if (issue) begin
          if (is_scan) begin
            cw_q   <= cw_q + 1'b1;
            more_q <= (cw_q != cend_q);
          end else begin
            if (cw_q == COL_LAST) begin
              cw_q <= '0;
              rw_q <= rw_q + 1'b1;
            end else begin
              cw_q <= cw_q + 1'b1;
            end
            more_q <= !((cw_q == COL_LAST) && (rw_q == ROW_LAST));
          end
        end
      end
    end
  end

  // image memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      img_mem[sw_q] <= fill;
    end else if (cmd_i.accept && in_mode == cls_pkg::MODE_WR_IMG && row_ok && col_ok) begin
      img_mem[wr_addr] <= item_i.char_value;
    end
    if (issue) begin
      img_rd_q <= img_mem[rd_addr];
    end
  end

  // shadow memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      shd_mem[sw_q] <= fill;
    end else if (walk_wr) begin
      shd_mem[rd_addr_q] <= img_rd_q;
    end
    if (issue) begin
      shd_rd_q <= shd_mem[rd_addr];
    end
  end

  // location of the cell in flight
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_addr_q <= rd_addr;
      rd_row_q  <= rw_q;
      rd_col_q  <= cw_q;
    end
  end

  // status
  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.sweep_last = sweep_last;
    sts_o.tr_last    = tr_last;
    sts_o.can_push   = can_push;
    sts_o.tag_adv    = tag_adv;
    sts_o.walk_done  = !more_q && !rd_v_q;
    sts_o.fin_ok     = !hold_v_q || out_free;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/cls_ctrl.sv -----
// controller state machine sequencing sweeps, tag checks and walks
module cls_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cls_pkg::item_t item_i,
  output logic           in_ready_o,
  input  cls_pkg::sts_t  sts_i,
  output cls_pkg::cmd_t  cmd_o
);

  cls_pkg::ctrl_state_e state_q, state_d;
  cls_pkg::mode_e       in_mode;

  assign in_mode = cls_pkg::mode_e'(item_i.mode);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cls_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cls_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = cls_pkg::ST_IDLE;
        end
      end
      cls_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_mode) inside
            cls_pkg::MODE_CLEAR: state_d = cls_pkg::ST_CLEAR;
            cls_pkg::MODE_SCAN, cls_pkg::MODE_CMP: begin
              state_d = item_i.with_tags ? cls_pkg::ST_TAGS : cls_pkg::ST_WALK;
            end
            cls_pkg::MODE_TAGS: state_d = cls_pkg::ST_TAGS;
            default: state_d = cls_pkg::ST_IDLE;
          endcase
        end
      end
      cls_pkg::ST_CLEAR: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.fill_space = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = cls_pkg::ST_LINES;
        end
      end
      cls_pkg::ST_LINES: begin
        cmd_o.line_step = 1'b1;
        if (sts_i.can_push && sts_i.tr_last) begin
          state_d = cls_pkg::ST_FINISH;
        end
      end
      cls_pkg::ST_TAGS: begin
        cmd_o.tag_step = 1'b1;
        if (sts_i.tag_adv && sts_i.tr_last) begin
          state_d = (sts_i.mode == cls_pkg::MODE_TAGS) ? cls_pkg::ST_FINISH
                                                       : cls_pkg::ST_WALK;
        end
      end
      cls_pkg::ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = cls_pkg::ST_FINISH;
        end
      end
      cls_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.fin_ok) begin
          state_d = cls_pkg::ST_IDLE;
        end
      end
      default: state_d = cls_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/char_lcd_shadow_diff.sv -----
// After reset a sweep over all ROWS*COLS cells fills both memories with zero; ready stays low.
// Image and tag writes are taken in idle. A scan walks col_first..col_last of one row and a line
// compare all cells, each after a tag check with tags; a clear fills both memories with spaces.
// Unless stalled, the walk does one read, compare and shadow write per cycle on one port of each
// memory. Results pass a hold slot and an output register; back-pressure stretches the item.
// top level of the character lcd shadow differ
module char_lcd_shadow_diff #(
  parameter int unsigned ROWS = cls_pkg::ROWS_DEF,
  parameter int unsigned COLS = cls_pkg::COLS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  cls_item_if.sink item_i,
  cls_res_if.source res_o
);

  cls_pkg::item_t item;
  cls_pkg::cmd_t  cmd;
  cls_pkg::sts_t  sts;
  cls_pkg::res_t  res;
  logic           in_ready;
  logic           out_valid;

  // pack the input payload
  always_comb begin
    item.mode       = item_i.mode;
    item.row        = item_i.row;
    item.col_first  = item_i.col_first;
    item.col_last   = item_i.col_last;
    item.char_value = item_i.char_value;
    item.with_tags  = item_i.with_tags;
  end

  assign item_i.ready = in_ready;

  cls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .item_i     (item),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cls_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  // unpack the result payload
  assign res_o.valid    = out_valid;
  assign res_o.kind     = res.kind;
  assign res_o.out_row  = res.out_row;
  assign res_o.out_col  = res.out_col;
  assign res_o.out_char = res.out_char;
  assign res_o.last     = res.last;

endmodule
